// ===== hdl/frpp_pkg.sv =====
// ----------------------------------------------------------------------------
// frpp_pkg
// Shared sizes, constants, register indexes and sequencer states for the
// frame-rate PID pacer.
// ----------------------------------------------------------------------------
package frpp_pkg;

   // Depth of the sliding sample window.
   localparam int WINDOW_LEN = 5;

   // Field widths.
   localparam int FPS_W  = 12;
   localparam int TGT_W  = 9;
   localparam int GAIN_W = 16;
   localparam int FRAC_W = 16;
   localparam int OUT_W  = 41;
   localparam int INT_W  = 48;

   // Window bookkeeping widths.
   localparam int PTR_W = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
   localparam int CNT_W = $clog2(WINDOW_LEN + 1);
   localparam int SUM_W = FPS_W + CNT_W;

   // Divider and arithmetic widths.
   localparam int DES_W  = 30;
   localparam int NUM_W  = DES_W + CNT_W;
   localparam int STEP_W = $clog2(NUM_W);
   localparam int ERR_W  = NUM_W + 1;
   localparam int DIFF_W = ERR_W + 1;
   localparam int PROD_W = DIFF_W + GAIN_W + 1;
   localparam int TOT_W  = PROD_W + 2;

   localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(NUM_W - 1);

   // One second in nanoseconds.
   localparam logic [DES_W-1:0] NS_PER_SEC = DES_W'(1000000000);

   // Configuration port.
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_ADDR_W-1:0] CSR_TARGET_FPS = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_P_GAIN     = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_I_GAIN     = 2'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_D_GAIN     = 2'd3;

   localparam logic [GAIN_W-1:0] P_GAIN_RESET = GAIN_W'(7864);
   localparam logic [GAIN_W-1:0] I_GAIN_RESET = GAIN_W'(3277);
   localparam logic [GAIN_W-1:0] D_GAIN_RESET = GAIN_W'(3932);

   // Sequencer states.
   typedef enum logic [3:0] {
      S_IDLE,
      S_DIV_DES,
      S_LOAD_ACT,
      S_DIV_ACT,
      S_ERR,
      S_MUL_I,
      S_INT_ADD,
      S_INT_CLAMP,
      S_ADD_I,
      S_ADD_D,
      S_OUT
   } state_type;

endpackage

// ===== hdl/frame_rate_pid_pacer.sv =====
// ----------------------------------------------------------------------------
// frame_rate_pid_pacer
// Windowed frame-rate PID controller with a clamped integral, built around
// one shared restoring divider and one shared multiplier under a sequencer.
// ----------------------------------------------------------------------------
// An enabled request runs the desired-time division, then the actual-time
// division (skipped when the window sum is zero), then the error, multiply,
// integrate, clamp and add steps; the bit-serial divider runs once for each
// division. A disabled request gives 0 in the cycle after acceptance. The next
// request can be taken in the cycle after the result is written.
// Reset (synchronous, active high) clears the window, state and result channel.
module frame_rate_pid_pacer
   import frpp_pkg::*;
(
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [FPS_W-1:0]             req_measured_fps,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic signed [OUT_W-1:0]      rsp_sleep_adjust_ns,
   input  logic                         csr_write,
   input  logic [CSR_ADDR_W-1:0]        csr_index,
   input  logic [CSR_DATA_W-1:0]        csr_data
);

   // Sequencer.
   state_type state_ff, state_in;

   // Configuration registers.
   logic [TGT_W-1:0]  target_ff, target_in;
   logic [GAIN_W-1:0] kp_ff, kp_in;
   logic [GAIN_W-1:0] ki_ff, ki_in;
   logic [GAIN_W-1:0] kd_ff, kd_in;

   // Sliding window.
   logic [FPS_W-1:0]  win_ff [WINDOW_LEN];
   logic [FPS_W-1:0]  win_in [WINDOW_LEN];
   logic [PTR_W-1:0]  head_ff, head_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [SUM_W-1:0]  sum_ff, sum_in;

   // Controller state.
   logic signed [INT_W-1:0] integ_ff, integ_in;
   logic signed [ERR_W-1:0] prev_err_ff, prev_err_in;

   // Shared divider.
   logic [NUM_W-1:0]  div_num_ff, div_num_in;
   logic [SUM_W-1:0]  div_rem_ff, div_rem_in;
   logic [SUM_W-1:0]  div_den_ff, div_den_in;
   logic [STEP_W-1:0] step_ff, step_in;

   // Working registers.
   logic [DES_W-1:0]         desired_ff, desired_in;
   logic signed [ERR_W-1:0]  err_ff, err_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic signed [TOT_W-1:0]  isum_ff, isum_in;
   logic signed [TOT_W-1:0]  acc_ff, acc_in;

   // Result channel.
   logic                    rsp_valid_ff, rsp_valid_in;
   logic signed [OUT_W-1:0] rsp_data_ff, rsp_data_in;

   // Handshake terms.
   logic req_accept;
   logic out_free;
   logic enabled;

   // Divider step.
   logic [SUM_W:0]   rem_shift;
   logic [SUM_W+1:0] trial;
   logic             trial_ge;

   // Multiplier operands.
   logic signed [DIFF_W-1:0] err_diff;
   logic signed [DIFF_W-1:0] mul_a;
   logic [GAIN_W-1:0]        mul_gain;
   logic signed [PROD_W-1:0] mul_out;

   // Clamp, rounding and error terms.
   logic signed [TOT_W-1:0] bound;
   logic signed [TOT_W-1:0] clamped;
   logic signed [TOT_W-1:0] rounded;
   logic signed [TOT_W-1:0] shifted;
   logic [ERR_W-1:0]        des_ext;
   logic [ERR_W-1:0]        act_ext;
   logic [FPS_W-1:0]        oldest;

   assign enabled    = (target_ff != '0);
   assign out_free   = ~rsp_valid_ff | ~rsp_stall;
   assign req_accept = req_valid & ~req_stall;

   // One bit of the restoring division per cycle.
   assign rem_shift = {div_rem_ff, div_num_ff[NUM_W-1]};
   assign trial     = {1'b0, rem_shift} - {2'b00, div_den_ff};
   assign trial_ge  = ~trial[SUM_W+1];

   // Multiplier input selection: the derivative pass uses the error change.
   assign err_diff = DIFF_W'(err_ff) - DIFF_W'(prev_err_ff);
   assign mul_a    = (state_ff == S_INT_CLAMP) ? err_diff : DIFF_W'(err_ff);
   assign mul_out  = PROD_W'(mul_a) * PROD_W'($signed({1'b0, mul_gain}));

   // Anti-windup clamp at half the desired frame time, 16 fractional bits.
   assign bound = $signed(TOT_W'(desired_ff) << (FRAC_W - 1));

   always_comb begin
      if (isum_ff > bound) begin
         clamped = bound;
      end else if (isum_ff < -bound) begin
         clamped = -bound;
      end else begin
         clamped = isum_ff;
      end
   end

   // Truncation toward zero of the 16 fractional bits.
   assign rounded = acc_ff + (acc_ff[TOT_W-1] ? TOT_W'((1 << FRAC_W) - 1) : TOT_W'(0));
   assign shifted = rounded >>> FRAC_W;

   // Error between desired and measured frame time.
   assign des_ext = ERR_W'(desired_ff);
   assign act_ext = (sum_ff == '0) ? des_ext : ERR_W'(div_num_ff);

   assign oldest = win_ff[head_ff];

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_accept && enabled) begin
               state_in = S_DIV_DES;
            end
         end
         S_DIV_DES: begin
            if (step_ff == STEP_LAST) begin
               state_in = S_LOAD_ACT;
            end
         end
         S_LOAD_ACT: begin
            state_in = (sum_ff == '0) ? S_ERR : S_DIV_ACT;
         end
         S_DIV_ACT: begin
            if (step_ff == STEP_LAST) begin
               state_in = S_ERR;
            end
         end
         S_ERR:       state_in = S_MUL_I;
         S_MUL_I:     state_in = S_INT_ADD;
         S_INT_ADD:   state_in = S_INT_CLAMP;
         S_INT_CLAMP: state_in = S_ADD_I;
         S_ADD_I:     state_in = S_ADD_D;
         S_ADD_D:     state_in = S_OUT;
         S_OUT: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default:     state_in = S_IDLE;
      endcase
   end

   // Sequencer outputs: request stall and gain selection.
   always_comb begin
      req_stall = 1'b1;
      mul_gain  = kd_ff;
      unique case (state_ff)
         S_IDLE:    req_stall = ~enabled & ~out_free;
         S_MUL_I:   mul_gain  = ki_ff;
         S_INT_ADD: mul_gain  = kp_ff;
         default:   mul_gain  = kd_ff;
      endcase
   end

   // Configuration writes.
   always_comb begin
      target_in = target_ff;
      kp_in     = kp_ff;
      ki_in     = ki_ff;
      kd_in     = kd_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_TARGET_FPS: target_in = csr_data[TGT_W-1:0];
            CSR_P_GAIN:     kp_in     = csr_data[GAIN_W-1:0];
            CSR_I_GAIN:     ki_in     = csr_data[GAIN_W-1:0];
            CSR_D_GAIN:     kd_in     = csr_data[GAIN_W-1:0];
            default:        target_in = target_ff;
         endcase
      end
   end

   // Window update when an enabled request is accepted.
   always_comb begin
      win_in   = win_ff;
      head_in  = head_ff;
      count_in = count_ff;
      sum_in   = sum_ff;
      if ((state_ff == S_IDLE) && req_accept && enabled) begin
         win_in[head_ff] = req_measured_fps;
         if (count_ff == CNT_W'(WINDOW_LEN)) begin
            sum_in = sum_ff - SUM_W'(oldest) + SUM_W'(req_measured_fps);
         end else begin
            count_in = count_ff + CNT_W'(1);
            sum_in   = sum_ff + SUM_W'(req_measured_fps);
         end
         head_in = (head_ff == PTR_W'(WINDOW_LEN - 1)) ? '0 : head_ff + PTR_W'(1);
      end
   end

   // Divider and arithmetic datapath.
   always_comb begin
      div_num_in  = div_num_ff;
      div_rem_in  = div_rem_ff;
      div_den_in  = div_den_ff;
      step_in     = step_ff;
      desired_in  = desired_ff;
      err_in      = err_ff;
      prod_in     = prod_ff;
      isum_in     = isum_ff;
      acc_in      = acc_ff;
      integ_in    = integ_ff;
      prev_err_in = prev_err_ff;
      case (state_ff)
         S_IDLE: begin
            // Desired frame time: one second over the target rate.
            div_num_in = NUM_W'(NS_PER_SEC);
            div_den_in = SUM_W'(target_ff);
            div_rem_in = '0;
            step_in    = '0;
         end
         S_DIV_DES, S_DIV_ACT: begin
            div_num_in = {div_num_ff[NUM_W-2:0], trial_ge};
            div_rem_in = trial_ge ? trial[SUM_W-1:0] : rem_shift[SUM_W-1:0];
            step_in    = step_ff + STEP_W'(1);
         end
         S_LOAD_ACT: begin
            // Actual frame time: count seconds over the window sum.
            desired_in = div_num_ff[DES_W-1:0];
            div_num_in = NUM_W'(NS_PER_SEC) * NUM_W'(count_ff);
            div_den_in = sum_ff;
            div_rem_in = '0;
            step_in    = '0;
         end
         S_ERR: begin
            err_in = $signed(des_ext - act_ext);
         end
         S_MUL_I: begin
            prod_in = mul_out;
         end
         S_INT_ADD: begin
            isum_in = TOT_W'(integ_ff) + TOT_W'(prod_ff);
            prod_in = mul_out;
         end
         S_INT_CLAMP: begin
            integ_in    = clamped[INT_W-1:0];
            acc_in      = TOT_W'(prod_ff);
            prod_in     = mul_out;
            prev_err_in = err_ff;
         end
         S_ADD_I: begin
            acc_in = acc_ff + TOT_W'(integ_ff);
         end
         S_ADD_D: begin
            acc_in = acc_ff + TOT_W'(prod_ff);
         end
         default: begin
            acc_in = acc_ff;
         end
      endcase
   end

   // Result register: a finished result waits here until it is taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      rsp_data_in  = rsp_data_ff;
      if ((state_ff == S_IDLE) && req_accept && !enabled) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = '0;
      end else if ((state_ff == S_OUT) && out_free) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = shifted[OUT_W-1:0];
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         target_ff    <= '0;
         kp_ff        <= P_GAIN_RESET;
         ki_ff        <= I_GAIN_RESET;
         kd_ff        <= D_GAIN_RESET;
         win_ff       <= '{default: '0};
         head_ff      <= '0;
         count_ff     <= '0;
         sum_ff       <= '0;
         integ_ff     <= '0;
         prev_err_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         target_ff    <= target_in;
         kp_ff        <= kp_in;
         ki_ff        <= ki_in;
         kd_ff        <= kd_in;
         win_ff       <= win_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         sum_ff       <= sum_in;
         integ_ff     <= integ_in;
         prev_err_ff  <= prev_err_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      div_num_ff  <= div_num_in;
      div_rem_ff  <= div_rem_in;
      div_den_ff  <= div_den_in;
      step_ff     <= step_in;
      desired_ff  <= desired_in;
      err_ff      <= err_in;
      prod_ff     <= prod_in;
      isum_ff     <= isum_in;
      acc_ff      <= acc_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_sleep_adjust_ns = rsp_data_ff;

endmodule

// ===== hdl/frpp_checker.sv =====
// ----------------------------------------------------------------------------
// frpp_checker
// Port-level checks for the frame-rate PID pacer, bound to the top level.
// ----------------------------------------------------------------------------
module frpp_checker
   import frpp_pkg::*;
(
   input logic                    clock,
   input logic                    reset,
   input logic                    req_valid,
   input logic                    req_stall,
   input logic [FPS_W-1:0]        req_measured_fps,
   input logic                    rsp_valid,
   input logic                    rsp_stall,
   input logic signed [OUT_W-1:0] rsp_sleep_adjust_ns,
   input logic                    csr_write,
   input logic [CSR_ADDR_W-1:0]   csr_index,
   input logic [CSR_DATA_W-1:0]   csr_data
);

   // Shadow of the target register, followed from the write port.
   logic [TGT_W-1:0] tgt_ff, tgt_in;
   logic             req_take;

   assign tgt_in   = (csr_write && (csr_index == CSR_TARGET_FPS)) ?
                     csr_data[TGT_W-1:0] : tgt_ff;
   assign req_take = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         tgt_ff <= '0;
      end else begin
         tgt_ff <= tgt_in;
      end
   end

   // Reset empties the result channel.
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // A stalled result holds its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_sleep_adjust_ns)))
      else $error("stalled result changed");

   // With the controller disabled, a request answers zero in the next cycle.
   a_disabled_zero: assert property (@(posedge clock) disable iff (reset)
      (req_take && (tgt_ff == '0) && (req_measured_fps == req_measured_fps))
      |=> (rsp_valid && (rsp_sleep_adjust_ns == '0)))
      else $error("disabled request did not give zero");

   // An enabled request occupies the block, so no request follows at once.
   a_enabled_busy: assert property (@(posedge clock) disable iff (reset)
      (req_take && (tgt_ff != '0)) |=> req_stall)
      else $error("request taken while the divider is busy");

endmodule

bind frame_rate_pid_pacer frpp_checker u_frpp_checker (
   .clock               (clock),
   .reset               (reset),
   .req_valid           (req_valid),
   .req_stall           (req_stall),
   .req_measured_fps    (req_measured_fps),
   .rsp_valid           (rsp_valid),
   .rsp_stall           (rsp_stall),
   .rsp_sleep_adjust_ns (rsp_sleep_adjust_ns),
   .csr_write           (csr_write),
   .csr_index           (csr_index),
   .csr_data            (csr_data)
);
